// ===== src/sdms_pkg.sv =====
// Shared constants, codes and types of the SIMT divergence mask stack unit.
`default_nettype none
package sdms_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int PC_BITS     = 16;
  localparam int LANES       = 64;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_IF      = 3'd1;
  localparam logic [2:0] CMD_ELSE    = 3'd2;
  localparam logic [2:0] CMD_ENDIF   = 3'd3;
  localparam logic [2:0] CMD_LOOP    = 3'd4;
  localparam logic [2:0] CMD_ENDLOOP = 3'd5;
  localparam logic [2:0] CMD_BARRIER = 3'd6;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_ELSE      = 3'd1;
  localparam logic [2:0] ERR_ENDIF     = 3'd2;
  localparam logic [2:0] ERR_ENDLOOP   = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;
  localparam logic [2:0] ERR_DIVERGENT = 3'd5;

  typedef struct packed {
    logic               is_loop;
    logic [LANES-1:0]   saved;
    logic [LANES-1:0]   then_m;
    logic [PC_BITS-1:0] pc;
  } stack_entry_t;

  typedef struct packed {
    logic         push;
    logic         pop;
    logic         clear;
    stack_entry_t entry;
  } stack_ctl_t;

endpackage
`default_nettype wire

// ===== src/sdms_stack.sv =====
// Reconvergence stack: entry storage and fill count.
`default_nettype none
module sdms_stack
  import sdms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  stack_ctl_t       ctl,
  output stack_entry_t     top,
  output logic [CNT_W-1:0] count
);

  stack_entry_t     entries [STACK_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] top_ptr;

  assign wr_ptr  = PTR_W'(count);
  assign top_ptr = PTR_W'(count - CNT_W'(1));
  assign top     = entries[top_ptr];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entries[wr_ptr] <= ctl.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.clear) begin
      count <= '0;
    end else if (ctl.push) begin
      count <= count + CNT_W'(1);
    end else if (ctl.pop) begin
      count <= count - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

// ===== src/simt_divergence_mask_stack_unit.sv =====
// Top level of the SIMT divergence mask stack unit.
// Takes one control instruction per clock. A request accepted at one edge is
// registered, then decoded against the exec mask and the top stack entry in a
// single pass, and its result is registered onto done and the result outputs;
// back-to-back requests see the state left by the one before. The receiver
// cannot stall: each result is valid for exactly one cycle. busy is high only
// during reset. The mask stack lives in flip-flops, so no clearing pass follows
// reset. wide_wave may be written only while no request is in flight.
`default_nettype none
module simt_divergence_mask_stack_unit
  import sdms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wide_wave_we,
  input  logic        wide_wave,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [63:0] cond_lanes,
  input  logic [15:0] next_pc,
  output logic        done,
  output logic [63:0] exec_mask,
  output logic        divergent,
  output logic        jump,
  output logic [15:0] jump_pc,
  output logic [4:0]  depth,
  output logic [2:0]  error
);

  logic             wide;
  logic             req_valid;
  logic [2:0]       req_cmd;
  logic [63:0]      req_cond;
  logic [15:0]      req_pc;
  logic [63:0]      exec_reg;
  logic [63:0]      exec_next;
  logic [63:0]      full;
  logic [63:0]      cond;
  logic [63:0]      left;
  logic [2:0]       err;
  logic             jmp;
  logic [15:0]      jpc;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] depth_after;
  logic             top_if;
  logic             top_loop;
  logic             stack_full;
  stack_ctl_t       ctl;
  stack_entry_t     top;

  assign busy = rst;

  sdms_stack u_stack (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .top   (top),
    .count (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wide <= 1'b0;
    end else if (wide_wave_we) begin
      wide <= wide_wave;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      req_cmd  <= cmd;
      req_cond <= cond_lanes;
      req_pc   <= next_pc;
    end
  end

  assign full       = wide ? {64{1'b1}} : {32'd0, 32'hFFFF_FFFF};
  assign cond       = req_cond & full;
  assign left       = exec_reg & cond;
  assign stack_full = (count >= CNT_W'(STACK_DEPTH));
  assign top_if     = (count != '0) && !top.is_loop;
  assign top_loop   = (count != '0) && top.is_loop;

  always_comb begin
    exec_next   = exec_reg;
    err         = ERR_NONE;
    jmp         = 1'b0;
    jpc         = '0;
    ctl         = '0;
    depth_after = count;
    if (req_valid) begin
      unique case (req_cmd)
        CMD_START: begin
          exec_next   = full;
          ctl.clear   = 1'b1;
          depth_after = '0;
        end
        CMD_IF: begin
          if (stack_full) begin
            err = ERR_OVERFLOW;
          end else begin
            ctl.push         = 1'b1;
            ctl.entry.is_loop = 1'b0;
            ctl.entry.saved  = exec_reg;
            ctl.entry.then_m = left;
            exec_next        = left;
            depth_after      = count + CNT_W'(1);
          end
        end
        CMD_ELSE: begin
          if (!top_if) begin
            err = ERR_ELSE;
          end else begin
            exec_next = top.saved & ~top.then_m;
          end
        end
        CMD_ENDIF: begin
          if (!top_if) begin
            err = ERR_ENDIF;
          end else begin
            exec_next   = top.saved;
            ctl.pop     = 1'b1;
            depth_after = count - CNT_W'(1);
          end
        end
        CMD_LOOP: begin
          if (stack_full) begin
            err = ERR_OVERFLOW;
          end else begin
            ctl.push          = 1'b1;
            ctl.entry.is_loop = 1'b1;
            ctl.entry.saved   = exec_reg;
            ctl.entry.pc      = PC_BITS'(req_pc);
            depth_after       = count + CNT_W'(1);
          end
        end
        CMD_ENDLOOP: begin
          if (!top_loop) begin
            err = ERR_ENDLOOP;
          end else if (left != '0) begin
            exec_next = left;
            jmp       = 1'b1;
            jpc       = 16'(top.pc);
          end else begin
            exec_next   = top.saved;
            ctl.pop     = 1'b1;
            depth_after = count - CNT_W'(1);
          end
        end
        CMD_BARRIER: begin
          if (exec_reg != full) begin
            err = ERR_DIVERGENT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exec_reg <= '0;
      done     <= 1'b0;
    end else begin
      done <= req_valid;
      if (req_valid) begin
        exec_reg <= exec_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      exec_mask <= exec_next;
      divergent <= (exec_next != '0) && (exec_next != full);
      jump      <= jmp;
      jump_pc   <= jpc;
      depth     <= 5'(depth_after);
      error     <= err;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_done_follows_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start & ~busy, 2))
    else $error("result without request");

  a_error_no_jump: assert property (@(posedge clk) disable iff (rst)
    done && (error != ERR_NONE) |-> !jump)
    else $error("jump on failed request");

  a_error_keeps_count: assert property (@(posedge clk) disable iff (rst)
    done && (error != ERR_NONE) |-> count == $past(count))
    else $error("failed request changed the stack");

  a_divergent_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && divergent |-> exec_mask != '0)
    else $error("divergent with empty mask");

endmodule
`default_nettype wire
